// ----- design/gyro_yaw_integrator_with_hold_top_assert.svh -----
// Assertion macros for the gyro yaw integrator modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef GYRO_YAW_INTEGRATOR_WITH_HOLD_TOP_ASSERT_SVH
`define GYRO_YAW_INTEGRATOR_WITH_HOLD_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GY_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gyro yaw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GY_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("gyro yaw assertion failed");

`endif

// ----- design/gyro_yaw_pkg.sv -----
// Shared types and constants of the gyro yaw integrator.
// Depends on nothing; imported by the controller, datapath and top level.
package gyro_yaw_pkg;

  // Field widths.
  localparam int GYRO_W   = 16;
  localparam int STAMP_W  = 32;
  localparam int OUT_W    = 40;
  localparam int OFS_W    = 24;
  localparam int THR_W    = 32;
  localparam int LOCK_W   = 16;
  localparam int IVL_W    = 10;
  localparam int RATE_W   = 25;
  localparam int INC_W    = RATE_W + IVL_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Default accumulator width.
  localparam int ACC_WIDTH_DEF = 48;

  // Output scaling: yaw_q16 = acc * 256 / 131000 = (acc << 5) / 16375.
  localparam int DIV_SHIFT = 5;
  localparam int DIV_REM_W = 14;
  localparam logic [DIV_REM_W:0] DIV_CONST = 15'd16375;
  // Quotient bits produced per divider cycle.
  localparam int DIV_BITS = 4;

  // Configuration reset values.
  localparam logic [OFS_W-1:0]  OFS_RST  = '0;
  localparam logic [THR_W-1:0]  THR_RST  = 32'd1006080;
  localparam logic [LOCK_W-1:0] LOCK_RST = 16'd50;
  localparam logic [IVL_W-1:0]  MAX_RST  = 10'd100;
  localparam logic [IVL_W-1:0]  FB_RST   = 10'd10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_OFFSET      = 3'd0,
    CFG_STABLE_THRESHOLD = 3'd1,
    CFG_LOCK_COUNT       = 3'd2,
    CFG_MAX_INTERVAL     = 3'd3,
    CFG_FALLBACK         = 3'd4
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input item, form interval and rate
    logic mul;       // rate times interval
    logic acc;       // saturating accumulate
    logic still;     // stillness test, counter and hold latch
    logic load;      // pick reported accumulator, load divider
    logic div_step;  // one divider iteration
    logic out_load;  // write the result register
  } dp_cmd_t;

endpackage

// ----- design/gyro_yaw_ctrl.sv -----
// Controller state machine of the gyro yaw integrator.
// Depends on gyro_yaw_pkg and the assertion macro header.
`include "gyro_yaw_integrator_with_hold_top_assert.svh"

module gyro_yaw_ctrl
  import gyro_yaw_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  localparam int DW    = ACC_WIDTH + DIV_SHIFT;
  localparam int NSTEP = (DW + DIV_BITS - 1) / DIV_BITS;
  localparam int CNT_W = $clog2(NSTEP);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NSTEP - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_STILL, S_LOAD, S_DIV, S_OUT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_tvalid_r;
  logic             out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Commands decoded from the state.
  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_tvalid;
    cmd.mul      = (state_r == S_MUL);
    cmd.acc      = (state_r == S_ACC);
    cmd.still    = (state_r == S_STILL);
    cmd.load     = (state_r == S_LOAD);
    cmd.div_step = (state_r == S_DIV);
    cmd.out_load = (state_r == S_OUT) && out_free;
  end

  // State, divider step count and result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_MUL;
          end
        end
        S_MUL:   state_r <= S_ACC;
        S_ACC:   state_r <= S_STILL;
        S_STILL: state_r <= S_LOAD;
        S_LOAD:  state_r <= S_DIV;
        S_DIV: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GY_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r == S_MUL)
  `GY_ASSERT_NEXT(a_out_written, clk, rst_n, (state_r == S_OUT) && out_free, out_tvalid_r && (state_r == S_IDLE))
  `GY_ASSERT_NOW(a_cnt_idle, clk, rst_n, state_r != S_DIV, cnt_r == '0)

endmodule

// ----- design/gyro_yaw_dp.sv -----
// Datapath of the gyro yaw integrator: configuration, integration state,
// stillness hold and the constant divider. Depends on gyro_yaw_pkg.
module gyro_yaw_dp
  import gyro_yaw_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [GYRO_W-1:0]     gyro_z,
  input  logic [STAMP_W-1:0]    timestamp_ms,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_W-1:0]      yaw_q16,
  output logic                  locked
);

  localparam int DW    = ACC_WIDTH + DIV_SHIFT;
  localparam int NSTEP = (DW + DIV_BITS - 1) / DIV_BITS;
  localparam int DPW   = NSTEP * DIV_BITS;

  // Configuration registers.
  logic [OFS_W-1:0]  gyro_offset_r;
  logic [THR_W-1:0]  stable_threshold_r;
  logic [LOCK_W-1:0] lock_count_r;
  logic [IVL_W-1:0]  max_interval_r;
  logic [IVL_W-1:0]  fallback_r;

  // Integration state.
  logic [STAMP_W-1:0]   last_stamp_r;
  logic [ACC_WIDTH-1:0] acc_r;
  logic [ACC_WIDTH-1:0] held_r;
  logic                 hold_r;
  logic [LOCK_W-1:0]    still_cnt_r;

  // Working registers.
  logic [RATE_W-1:0]    rate_r;
  logic [IVL_W-1:0]     dt_r;
  logic [INC_W-1:0]     inc_r;
  logic [ACC_WIDTH-1:0] old_r;
  logic                 neg_r;
  logic                 locked_r;
  logic [DPW-1:0]       quo_r;
  logic [DIV_REM_W-1:0] rem_r;
  logic [OUT_W-1:0]     yaw_r;
  logic                 locked_out_r;

  // Combinational values.
  logic [STAMP_W-1:0]   dt_diff;
  logic [IVL_W-1:0]     dt_nxt;
  logic [RATE_W-1:0]    rate_nxt;
  logic [ACC_WIDTH:0]   sum;
  logic [ACC_WIDTH-1:0] acc_nxt;
  logic [ACC_WIDTH:0]   delta;
  logic [ACC_WIDTH:0]   thr_ext;
  logic                 is_still;
  logic [LOCK_W-1:0]    cnt_nxt;
  logic                 hold_nxt;
  logic                 latch;
  logic [ACC_WIDTH-1:0] sel_acc;
  logic [ACC_WIDTH-1:0] mag;
  logic [DPW-1:0]       quo_nxt;
  logic [DIV_REM_W-1:0] rem_nxt;
  logic [OUT_W-1:0]     q40;

  // Interval and bias-corrected rate of the incoming item.
  always_comb begin
    dt_diff = timestamp_ms - last_stamp_r;
    if ((dt_diff == '0) || (dt_diff > {{(STAMP_W-IVL_W){1'b0}}, max_interval_r})) begin
      dt_nxt = fallback_r;
    end else begin
      dt_nxt = dt_diff[IVL_W-1:0];
    end
    rate_nxt = {gyro_z[GYRO_W-1], gyro_z, 8'h00}
             - {gyro_offset_r[OFS_W-1], gyro_offset_r};
  end

  // Saturating accumulate.
  always_comb begin
    sum = {acc_r[ACC_WIDTH-1], acc_r}
        + {{(ACC_WIDTH+1-INC_W){inc_r[INC_W-1]}}, inc_r};
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      acc_nxt = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_nxt = sum[ACC_WIDTH-1:0];
    end
  end

  // Stillness test on the change actually taken, still counter and latch.
  always_comb begin
    delta    = {acc_r[ACC_WIDTH-1], acc_r} - {old_r[ACC_WIDTH-1], old_r};
    thr_ext  = {{(ACC_WIDTH+1-THR_W){1'b0}}, stable_threshold_r};
    is_still = ($signed(delta) < $signed(thr_ext)) &&
               ($signed(delta) > -$signed(thr_ext));
    if (is_still) begin
      cnt_nxt  = (still_cnt_r == '1) ? still_cnt_r : still_cnt_r + 1'b1;
      hold_nxt = hold_r;
    end else begin
      cnt_nxt  = '0;
      hold_nxt = 1'b0;
    end
    latch = (cnt_nxt > lock_count_r) && !hold_nxt;
  end

  // Reported accumulator and its magnitude.
  always_comb begin
    sel_acc = hold_r ? held_r : acc_r;
    mag     = sel_acc[ACC_WIDTH-1] ? (~sel_acc + 1'b1) : sel_acc;
  end

  // Restoring division by the constant, DIV_BITS quotient bits per cycle.
  always_comb begin
    logic [DIV_REM_W:0] r;
    logic [DPW-1:0]     x;
    r = '0;
    x = quo_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {rem_nxt, x[DPW-1]};
      x = {x[DPW-2:0], 1'b0};
      if (r >= DIV_CONST) begin
        r    = r - DIV_CONST;
        x[0] = 1'b1;
      end
      rem_nxt = r[DIV_REM_W-1:0];
    end
    quo_nxt = x;
  end

  assign q40 = quo_r[OUT_W-1:0];

  // Configuration writes and integration state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_offset_r      <= OFS_RST;
      stable_threshold_r <= THR_RST;
      lock_count_r       <= LOCK_RST;
      max_interval_r     <= MAX_RST;
      fallback_r         <= FB_RST;
      last_stamp_r       <= '0;
      acc_r              <= '0;
      held_r             <= '0;
      hold_r             <= 1'b0;
      still_cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GYRO_OFFSET:      gyro_offset_r      <= cfg_data[OFS_W-1:0];
          CFG_STABLE_THRESHOLD: stable_threshold_r <= cfg_data[THR_W-1:0];
          CFG_LOCK_COUNT:       lock_count_r       <= cfg_data[LOCK_W-1:0];
          CFG_MAX_INTERVAL:     max_interval_r     <= cfg_data[IVL_W-1:0];
          CFG_FALLBACK:         fallback_r         <= cfg_data[IVL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        last_stamp_r <= timestamp_ms;
      end
      if (cmd.acc) begin
        acc_r <= acc_nxt;
      end
      if (cmd.still) begin
        still_cnt_r <= cnt_nxt;
        hold_r      <= hold_nxt || latch;
        if (latch) begin
          held_r <= acc_r;
        end
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dt_r   <= dt_nxt;
      rate_r <= rate_nxt;
    end
    if (cmd.mul) begin
      inc_r <= INC_W'($signed(rate_r) * $signed({1'b0, dt_r}));
    end
    if (cmd.acc) begin
      old_r <= acc_r;
    end
    if (cmd.load) begin
      neg_r    <= sel_acc[ACC_WIDTH-1];
      locked_r <= hold_r;
      quo_r    <= {{(DPW-DW){1'b0}}, mag, {DIV_SHIFT{1'b0}}};
      rem_r    <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      yaw_r        <= neg_r ? (~q40 + 1'b1) : q40;
      locked_out_r <= locked_r;
    end
  end

  assign yaw_q16 = yaw_r;
  assign locked  = locked_out_r;

endmodule

// ----- design/gyro_yaw_integrator_with_hold_top.sv -----
// Top level of the gyro yaw integrator with stillness hold.
// Depends on gyro_yaw_pkg, gyro_yaw_ctrl and gyro_yaw_dp.
//
// Usage: each item on the in_ channel carries a signed raw gyro Z sample and
// a millisecond timestamp. The block integrates the bias-corrected rate over
// the measured interval and returns one item per input on the out_ channel:
// the yaw in degrees with 16 fraction bits and, in out_tuser, a flag that is
// set while the held yaw is reported instead of the live one.
// Registers are written on the cfg_ channel, which is always ready; write
// them only while no item is in flight.
// Flow: an accepted item passes through the multiply, accumulate, stillness,
// divider load, divide and output states before the result is valid. The
// output scaling divider yields 4 quotient bits per cycle; one item is in
// work at a time, and the next item is accepted only once the controller
// is back in idle.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and worked on, and waits to be written until the
// register is free.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the accumulator, the hold, the still counter and the last timestamp.
module gyro_yaw_integrator_with_hold_top
  import gyro_yaw_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel. tdata: gyro_z [15:0], timestamp_ms [47:16].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,
  // Result channel. tdata: yaw_q16 [39:0].
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,
  // tuser: locked [0].
  output logic [0:0]            out_tuser,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  logic    locked;

  assign cfg_ready = 1'b1;

  gyro_yaw_ctrl #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gyro_yaw_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .gyro_z       (in_tdata[GYRO_W-1:0]),
    .timestamp_ms (in_tdata[GYRO_W+STAMP_W-1:GYRO_W]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .yaw_q16      (out_tdata),
    .locked       (locked)
  );

  assign out_tuser[0] = locked;

endmodule
